/* rtl/spq_pkg.sv */
`default_nettype none

package spq_pkg;

   // Queue geometry.
   localparam int CAPACITY     = 64;
   localparam int PAYLOAD_BITS = 16;
   localparam int PRIO_BITS    = 32;
   localparam int ADDR_W       = $clog2(CAPACITY);
   localparam int CNT_W        = $clog2(CAPACITY + 1);
   localparam int ENTRY_W      = PRIO_BITS + PAYLOAD_BITS;

   // Field widths on the ports.
   localparam int MODE_W   = 1;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 7;
   localparam int FPAY_W   = 16;

   // Request tdata layout: prio, then payload, padded to whole bytes.
   localparam int REQ_PRIO_LSB = 0;
   localparam int REQ_PAY_LSB  = PRIO_BITS;
   localparam int REQ_DATA_W   = ((PRIO_BITS + PAYLOAD_BITS + 7) / 8) * 8;

   // Response tdata layout: is_empty, front_payload, front_prio, occupancy.
   localparam int RSP_EMPTY_BIT = 0;
   localparam int RSP_PAY_LSB   = 1;
   localparam int RSP_PRIO_LSB  = RSP_PAY_LSB + FPAY_W;
   localparam int RSP_OCC_LSB   = RSP_PRIO_LSB + PRIO_BITS;
   localparam int RSP_USED_W    = RSP_OCC_LSB + OCC_W;
   localparam int RSP_DATA_W    = ((RSP_USED_W + 7) / 8) * 8;

   // Operation selector carried in req_tuser.
   localparam logic [MODE_W-1:0] MODE_INSERT = 1'b0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 1'b1;

   // Result status codes carried in rsp_tuser.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_code_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_item;  // capture the request and work out its status
      logic start_ins;  // grow the queue and aim the scan at the tail
      logic do_remove;  // drop the front entry
      logic rd_scan;    // read the entry under the scan pointer
      logic shift;      // move the entry just read up by one slot
      logic place;      // write the new entry above the scan pointer
      logic rd_front;   // read the front entry
      logic load_rsp;   // load the response register
   } spq_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_remove;  // current item is a remove
      logic full;       // queue holds CAPACITY entries
      logic empty;      // queue holds no entries
      logic greater;    // entry just read has a larger priority than the new one
      logic cnt_one;    // the entry just read is the last one to examine
      logic rsp_busy;   // response register holds an item not yet taken
   } spq_flags_type;

   // Slot addresses wrap around the circular buffer.
   function automatic logic [ADDR_W-1:0] addr_inc(input logic [ADDR_W-1:0] a);
      logic [ADDR_W-1:0] r;
      if (a == ADDR_W'(CAPACITY - 1)) begin
         r = '0;
      end else begin
         r = a + 1'b1;
      end
      return r;
   endfunction

   function automatic logic [ADDR_W-1:0] addr_dec(input logic [ADDR_W-1:0] a);
      logic [ADDR_W-1:0] r;
      if (a == '0) begin
         r = ADDR_W'(CAPACITY - 1);
      end else begin
         r = a - 1'b1;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/spq_ctrl.sv */
`default_nettype none

module spq_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   input  wire spq_pkg::spq_flags_type flags,
   output spq_pkg::spq_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_RD,
      S_CMP,
      S_PLACE,
      S_FRONT_RD,
      S_FRONT_WB
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and command decode.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (!flags.is_remove && !flags.full) begin
               cmd.start_ins = 1'b1;
               state_in      = flags.empty ? S_PLACE : S_RD;
            end else if (flags.is_remove && !flags.empty) begin
               cmd.do_remove = 1'b1;
               state_in      = S_FRONT_RD;
            end else begin
               state_in = S_FRONT_RD;
            end
         end
         S_RD: begin
            cmd.rd_scan = 1'b1;
            state_in    = S_CMP;
         end
         S_CMP: begin
            if (flags.greater) begin
               cmd.shift = 1'b1;
               state_in  = flags.cnt_one ? S_PLACE : S_RD;
            end else begin
               cmd.place = 1'b1;
               state_in  = S_FRONT_RD;
            end
         end
         S_PLACE: begin
            cmd.place = 1'b1;
            state_in  = S_FRONT_RD;
         end
         S_FRONT_RD: begin
            cmd.rd_front = 1'b1;
            state_in     = S_FRONT_WB;
         end
         S_FRONT_WB: begin
            if (!flags.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/spq_datapath.sv */
`default_nettype none

module spq_datapath (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire  [spq_pkg::MODE_W-1:0]            req_tuser,
   input  wire  [spq_pkg::REQ_DATA_W-1:0]        req_tdata,
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   output logic [spq_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic [spq_pkg::STATUS_W-1:0]          rsp_tuser,
   input  wire spq_pkg::spq_cmd_type             cmd,
   output spq_pkg::spq_flags_type                flags
);

   localparam int AW = spq_pkg::ADDR_W;
   localparam int CW = spq_pkg::CNT_W;
   localparam int EW = spq_pkg::ENTRY_W;
   localparam int PB = spq_pkg::PRIO_BITS;
   localparam int DB = spq_pkg::PAYLOAD_BITS;

   // Entry store: priority in the upper bits, payload in the lower bits.
   logic [EW-1:0] mem [spq_pkg::CAPACITY];
   logic [EW-1:0] rd_data_ff;

   // Queue bookkeeping.
   logic [AW-1:0] head_ff, tail_ff, ptr_ff;
   logic [CW-1:0] fill_ff, cnt_ff;

   // Current item.
   logic [spq_pkg::MODE_W-1:0] mode_ff;
   logic [PB-1:0]              new_prio_ff;
   logic [DB-1:0]              new_pay_ff;
   spq_pkg::status_code_type   status_ff;

   // Response register.
   logic                          rsp_valid_ff;
   logic [spq_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic [spq_pkg::STATUS_W-1:0]  rsp_user_ff;

   logic full, empty;
   logic [PB-1:0] rd_prio;
   logic [DB-1:0] rd_pay;
   logic [AW-1:0] rd_addr, wr_addr;
   logic          rd_en, wr_en;
   logic [EW-1:0] wr_data;
   logic [spq_pkg::RSP_DATA_W-1:0] rsp_next;

   assign full    = (fill_ff == CW'(spq_pkg::CAPACITY));
   assign empty   = (fill_ff == '0);
   assign rd_prio = rd_data_ff[EW-1:DB];
   assign rd_pay  = rd_data_ff[DB-1:0];

   // Status back to the controller.
   assign flags.is_remove = (mode_ff == spq_pkg::MODE_REMOVE);
   assign flags.full      = full;
   assign flags.empty     = empty;
   assign flags.greater   = (rd_prio > new_prio_ff);
   assign flags.cnt_one   = (cnt_ff == CW'(1));
   assign flags.rsp_busy  = rsp_valid_ff && !rsp_tready;

   // Memory port selection: shifted entries and the new one go one slot above the pointer.
   assign rd_en   = cmd.rd_scan || cmd.rd_front;
   assign rd_addr = cmd.rd_front ? head_ff : ptr_ff;
   assign wr_en   = cmd.shift || cmd.place;
   assign wr_addr = spq_pkg::addr_inc(ptr_ff);
   assign wr_data = cmd.shift ? rd_data_ff : {new_prio_ff, new_pay_ff};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Item capture and status decision.
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         mode_ff     <= req_tuser;
         new_prio_ff <= req_tdata[spq_pkg::REQ_PRIO_LSB +: PB];
         new_pay_ff  <= req_tdata[spq_pkg::REQ_PAY_LSB +: DB];
         if (req_tuser == spq_pkg::MODE_REMOVE) begin
            status_ff <= empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_OK;
         end else begin
            status_ff <= full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
         end
      end
   end

   // Head, tail, fill count and scan pointer.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         if (cmd.start_ins) begin
            tail_ff <= spq_pkg::addr_inc(tail_ff);
            fill_ff <= fill_ff + 1'b1;
         end else if (cmd.do_remove) begin
            head_ff <= spq_pkg::addr_inc(head_ff);
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_ins) begin
         ptr_ff <= spq_pkg::addr_dec(tail_ff);
         cnt_ff <= fill_ff;
      end else if (cmd.shift) begin
         ptr_ff <= spq_pkg::addr_dec(ptr_ff);
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   // Response word; an empty queue reports a zero front entry.
   always_comb begin
      rsp_next = '0;
      rsp_next[spq_pkg::RSP_EMPTY_BIT] = empty;
      if (!empty) begin
         rsp_next[spq_pkg::RSP_PAY_LSB +: spq_pkg::FPAY_W] = spq_pkg::FPAY_W'(rd_pay);
         rsp_next[spq_pkg::RSP_PRIO_LSB +: PB]            = rd_prio;
      end
      rsp_next[spq_pkg::RSP_OCC_LSB +: spq_pkg::OCC_W] = spq_pkg::OCC_W'(fill_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_data_ff <= rsp_next;
         rsp_user_ff <= status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

/* rtl/sorted_priority_queue.sv */
`default_nettype none

// Channel   Direction  Handshake              Contents
// req_      in         req_tvalid/req_tready  tuser: mode; tdata: prio, payload
// rsp_      out        rsp_tvalid/rsp_tready  tuser: status; tdata: is_empty,
//                                             front_payload, front_prio, occupancy
//
// One item is worked on at a time. An insert scans the single-port entry memory from
// the tail down: it reads an entry, compares it with the new one and moves it up one
// slot if its priority is larger, until it meets one that is not larger or passes the
// front, and then writes the new entry into the slot above.
// Reset clears the fill count, the ring pointers and the response valid, not the memory.
// A stalled response holds the controller before it loads the result, so input waits too.

module sorted_priority_queue (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire  [spq_pkg::REQ_DATA_W-1:0]    req_tdata,  // prio[31:0], payload[47:32]
   input  wire  [spq_pkg::MODE_W-1:0]        req_tuser,  // mode[0]
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [spq_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // is_empty[0], front_payload[16:1],
                                                         // front_prio[48:17], occupancy[55:49]
   output logic [spq_pkg::STATUS_W-1:0]      rsp_tuser   // status[1:0]
);

   spq_pkg::spq_cmd_type   cmd;
   spq_pkg::spq_flags_type flags;

   // Sequencer.
   spq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .flags      (flags),
      .cmd        (cmd)
   );

   // Entry store, ring pointers and response register.
   spq_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .flags      (flags)
   );

endmodule

`default_nettype wire

/* rtl/spq_checker.sv */
`default_nettype none

module spq_checker (
   input wire                               clock,
   input wire                               reset,
   input wire                               rsp_tvalid,
   input wire                               rsp_tready,
   input wire [spq_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input wire [spq_pkg::STATUS_W-1:0]       rsp_tuser
);

   localparam int OL = spq_pkg::RSP_OCC_LSB;
   localparam int OW = spq_pkg::OCC_W;

   // A stalled result keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // An empty queue reports zero occupancy and a zero front entry.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[spq_pkg::RSP_EMPTY_BIT]
      |-> rsp_tdata[spq_pkg::RSP_USED_W-1:1] == '0)
      else $error("empty queue reports stored data");

   // A refused remove only happens on an empty queue.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == spq_pkg::ST_EMPTY |-> rsp_tdata[spq_pkg::RSP_EMPTY_BIT])
      else $error("remove refused on a non-empty queue");

   // A refused insert only happens on a full queue.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == spq_pkg::ST_FULL
      |-> rsp_tdata[OL +: OW] == OW'(spq_pkg::CAPACITY))
      else $error("insert refused on a queue that is not full");

   // Occupancy never exceeds the capacity.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[OL +: OW] <= OW'(spq_pkg::CAPACITY))
      else $error("occupancy beyond capacity");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

/* dv/spq_order_checker.sv */
`timescale 1ns / 100ps

// Watches both channels of the priority queue, keeps its own sorted copy of the
// stored entries and checks every result item against the copy.
module spq_order_checker (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   input  wire                               req_tready,
   input  wire  [spq_pkg::REQ_DATA_W-1:0]    req_tdata,  // prio[31:0], payload[47:32]
   input  wire  [spq_pkg::MODE_W-1:0]        req_tuser,  // mode[0]
   input  wire                               rsp_tvalid,
   input  wire                               rsp_tready,
   input  wire  [spq_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // is_empty[0], front_payload[16:1],
                                                         // front_prio[48:17], occupancy[55:49]
   input  wire  [spq_pkg::STATUS_W-1:0]      rsp_tuser,  // status[1:0]
   output int                                mismatch_count,
   output int                                outstanding,
   output int                                results_seen,
   output int                                full_refusals,
   output int                                empty_refusals,
   output int                                peak_fill
);

   localparam int REPORT_LIMIT = 10;
   localparam int PB           = spq_pkg::PRIO_BITS;
   localparam int DB           = spq_pkg::PAYLOAD_BITS;
   localparam int FW           = spq_pkg::FPAY_W;
   localparam int OW           = spq_pkg::OCC_W;

   typedef struct {
      logic [PB-1:0] prio;
      logic [DB-1:0] payload;
   } entry_type;

   typedef struct {
      spq_pkg::status_code_type status;
      logic                     is_empty;
      logic [FW-1:0]            front_payload;
      logic [PB-1:0]            front_prio;
      logic [OW-1:0]            occupancy;
   } outcome_type;

   // Sorted copy of the queue contents, front first.
   entry_type   held_entries[$];
   // Results that the block still owes, oldest first.
   outcome_type awaited_outcomes[$];

   // Applies one insert or remove to the sorted copy and works out the result.
   function automatic outcome_type apply_request(input logic [spq_pkg::MODE_W-1:0] mode,
                                                 input logic [PB-1:0]              prio,
                                                 input logic [DB-1:0]              payload);
      outcome_type o;
      entry_type   e;
      int          pos;
      o.status = spq_pkg::ST_OK;
      if (mode == spq_pkg::MODE_REMOVE) begin
         if (held_entries.size() == 0) begin
            o.status = spq_pkg::ST_EMPTY;
         end else begin
            void'(held_entries.pop_front());
         end
      end else if (held_entries.size() >= spq_pkg::CAPACITY) begin
         o.status = spq_pkg::ST_FULL;
      end else begin
         // Equal priorities go behind the ones already stored.
         pos = 0;
         while (pos < held_entries.size() && held_entries[pos].prio <= prio) begin
            pos++;
         end
         e.prio    = prio;
         e.payload = payload;
         held_entries.insert(pos, e);
      end
      o.is_empty  = (held_entries.size() == 0);
      o.occupancy = OW'(held_entries.size());
      if (o.is_empty) begin
         o.front_payload = '0;
         o.front_prio    = '0;
      end else begin
         o.front_payload = FW'(held_entries[0].payload);
         o.front_prio    = held_entries[0].prio;
      end
      return o;
   endfunction

   function automatic string show_outcome(input outcome_type o);
      return $sformatf("status=%0d empty=%0b payload=%h prio=%h occ=%0d",
                       o.status, o.is_empty, o.front_payload, o.front_prio, o.occupancy);
   endfunction

   // Prediction on each accepted request item, comparison on each accepted result item.
   always @(posedge clock) begin : watch
      outcome_type want;
      outcome_type got;
      if (reset) begin
         held_entries.delete();
         awaited_outcomes.delete();
         mismatch_count = 0;
         outstanding    = 0;
         results_seen   = 0;
         full_refusals  = 0;
         empty_refusals = 0;
         peak_fill      = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            want = apply_request(req_tuser, req_tdata[spq_pkg::REQ_PRIO_LSB +: PB],
                                 req_tdata[spq_pkg::REQ_PAY_LSB +: DB]);
            awaited_outcomes.push_back(want);
            if (want.status == spq_pkg::ST_FULL) begin
               full_refusals++;
            end
            if (want.status == spq_pkg::ST_EMPTY) begin
               empty_refusals++;
            end
            if (int'(want.occupancy) > peak_fill) begin
               peak_fill = int'(want.occupancy);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got.status        = spq_pkg::status_code_type'(rsp_tuser);
            got.is_empty      = rsp_tdata[spq_pkg::RSP_EMPTY_BIT];
            got.front_payload = rsp_tdata[spq_pkg::RSP_PAY_LSB +: FW];
            got.front_prio    = rsp_tdata[spq_pkg::RSP_PRIO_LSB +: PB];
            got.occupancy     = rsp_tdata[spq_pkg::RSP_OCC_LSB +: OW];
            results_seen++;
            if (awaited_outcomes.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("%t: result item with none awaited: %s", $time,
                           show_outcome(got));
               end
            end else begin
               want = awaited_outcomes.pop_front();
               if (got.status !== want.status || got.is_empty !== want.is_empty ||
                   got.front_payload !== want.front_payload ||
                   got.front_prio !== want.front_prio ||
                   got.occupancy !== want.occupancy) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("%t: result item %0d differs", $time, results_seen);
                     $display("   expected %s", show_outcome(want));
                     $display("   actual   %s", show_outcome(got));
                  end
               end
            end
         end
         outstanding = awaited_outcomes.size();
      end
   end

endmodule

/* dv/sorted_priority_queue_test.sv */
`timescale 1ns / 100ps

module sorted_priority_queue_test;

   localparam int QUIET_LIMIT   = 4000;  // cycles with no item moving on either channel
   localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
   localparam int DRAIN_CYCLES  = 200;   // beyond the longest insert scan
   localparam int PHASE_ITEMS   = 300;
   localparam int SEGMENT_ITEMS = 100;
   localparam int PB            = spq_pkg::PRIO_BITS;
   localparam int DB            = spq_pkg::PAYLOAD_BITS;

   logic                               clock;
   logic                               reset      = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [spq_pkg::REQ_DATA_W-1:0]     req_tdata  = '0;
   logic [spq_pkg::MODE_W-1:0]         req_tuser  = spq_pkg::MODE_INSERT;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [spq_pkg::RSP_DATA_W-1:0]     rsp_tdata;
   logic [spq_pkg::STATUS_W-1:0]       rsp_tuser;

   int                        mismatch_count;
   int                        outstanding;
   int                        results_seen;
   int                        full_refusals;
   int                        empty_refusals;
   int                        peak_fill;

   int unsigned               send_idle_pct = 0;
   int unsigned               rx_stall_pct  = 0;
   logic                      hold_active   = 1'b0;
   int unsigned               quiet_cycles  = 0;

   int unsigned               tx_idle_by_phase[4] = '{0, 50, 0, 29};
   int unsigned               rx_stall_by_phase[4] = '{0, 0, 50, 29};

   sorted_priority_queue dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   spq_order_checker order_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding),
      .results_seen   (results_seen),
      .full_refusals  (full_refusals),
      .empty_refusals (empty_refusals),
      .peak_fill      (peak_fill)
   );

   // 10 ns clock.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Result side: random stalls, or a solid hold-off while one is requested.
   always @(posedge clock) begin
      if (hold_active) begin
         rsp_tready <= 1'b0;
      end else if (rx_stall_pct == 0) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // Count cycles in which no item moves on either channel.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : watchdog
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("Timeout after %0d cycles without an item moving.", QUIET_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   // Offers one request item, with random idle cycles ahead of it, and waits for it
   // to be taken.
   task automatic push_item(input logic [spq_pkg::MODE_W-1:0] mode,
                            input logic [PB-1:0]              prio,
                            input logic [DB-1:0]              payload);
      logic [spq_pkg::REQ_DATA_W-1:0] word;
      word = '0;
      word[spq_pkg::REQ_PRIO_LSB +: PB] = prio;
      word[spq_pkg::REQ_PAY_LSB +: DB]  = payload;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= word;
      do begin
         @(posedge clock);
      end while (!req_tready);
   endtask

   // One random request item; priorities lean towards ties and the extremes.
   task automatic push_random(input int unsigned insert_pct);
      logic [spq_pkg::MODE_W-1:0] mode;
      logic [PB-1:0]              prio;
      mode = ($urandom_range(99) < insert_pct) ? spq_pkg::MODE_INSERT : spq_pkg::MODE_REMOVE;
      case ($urandom_range(3))
         0: begin
            prio = PB'($urandom_range(7));
         end
         1: begin
            prio = PB'($urandom);
         end
         2: begin
            prio = $urandom_range(1) ? '1 : '0;
         end
         default: begin
            prio = 32'h8000_0000 + PB'($urandom_range(15));
         end
      endcase
      push_item(mode, prio, DB'($urandom));
   endtask

   initial begin : stimulus
      int ph;
      int k;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: remove from empty, extreme keys and payloads, ties at front,
      // middle and tail, then drain and remove from empty once more.
      push_item(spq_pkg::MODE_REMOVE, '1, '1);
      push_item(spq_pkg::MODE_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
      push_item(spq_pkg::MODE_INSERT, 32'h0000_0000, 16'h0000);
      push_item(spq_pkg::MODE_INSERT, 32'h8000_0000, 16'h1111);
      push_item(spq_pkg::MODE_INSERT, 32'h8000_0000, 16'h2222);
      push_item(spq_pkg::MODE_INSERT, 32'h8000_0000, 16'h3333);
      push_item(spq_pkg::MODE_INSERT, 32'h7FFF_FFFF, 16'h8000);
      push_item(spq_pkg::MODE_INSERT, 32'h0000_0001, 16'h0001);
      push_item(spq_pkg::MODE_INSERT, 32'h0000_0000, 16'hAAAA);
      push_item(spq_pkg::MODE_INSERT, 32'hFFFF_FFFF, 16'h5555);
      for (k = 0; k < 10; k++) begin
         push_item(spq_pkg::MODE_REMOVE, PB'($urandom), DB'($urandom));
      end

      // Random: each handshake phase fills the queue past full, mixes, then drains
      // it past empty.
      for (ph = 0; ph < 4; ph++) begin
         send_idle_pct = tx_idle_by_phase[ph];
         rx_stall_pct <= rx_stall_by_phase[ph];
         for (k = 0; k < PHASE_ITEMS; k++) begin
            if (ph == 0 && k == SEGMENT_ITEMS) begin
               fork
                  begin
                     hold_active <= 1'b1;
                     repeat (HOLD_CYCLES) @(posedge clock);
                     hold_active <= 1'b0;
                  end
               join_none
            end
            if (k < SEGMENT_ITEMS) begin
               push_random(85);
            end else if (k < 2 * SEGMENT_ITEMS) begin
               push_random(50);
            end else begin
               push_random(15);
            end
         end
      end
      req_tvalid <= 1'b0;
      rx_stall_pct <= 0;

      wait (outstanding == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d result items over four handshake phases and one long hold-off.",
               results_seen);
      $display("Inserts refused when full: %0d, removes refused when empty: %0d, peak fill %0d.",
               full_refusals, empty_refusals, peak_fill);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("%0d mismatches, %0d results never arrived.", mismatch_count, outstanding);
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* sorted_priority_queue.f */
rtl/spq_pkg.sv
rtl/spq_ctrl.sv
rtl/spq_datapath.sv
rtl/sorted_priority_queue.sv
rtl/spq_checker.sv
dv/spq_order_checker.sv
dv/sorted_priority_queue_test.sv
